// ===== rtl/dda_pkg.sv =====
// ----------------------------------------------------------------------------
// dda_pkg: shared types and constants of the DDA line rasterizer
// Holds the function codes of the input word and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COLOR_BITS = 24;

    // Function codes carried in the input word's tuser bit.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_line;  // latch endpoints and color, set up the divider
        logic advance;    // step both accumulators by one pixel
        logic div_step;   // one restoring-division iteration on both lanes
    } dda_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic steps_zero;   // incoming endpoints are equal
        logic final_pixel;  // the next tick produces the last pixel
    } dda_stat_t;

endpackage

// ===== rtl/dda_ctrl.sv =====
// ----------------------------------------------------------------------------
// dda_ctrl: sequencer of the DDA line rasterizer
// Decodes accepted words, runs the divider for the increments and tracks
// whether a line is in progress.
// ----------------------------------------------------------------------------
module dda_ctrl #(
    parameter int DIV_LEN = 25
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    output logic                s_tready,
    input  logic                skid_full,
    input  dda_pkg::dda_stat_t  stat,
    output dda_pkg::dda_cmd_t   cmd,
    output logic                push,
    output logic                push_last,
    output logic                busy,
    output logic                dividing
);
    import dda_pkg::*;

    localparam int CNT_W = (DIV_LEN > 1) ? $clog2(DIV_LEN) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_LEN - 1);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_DIV  = 1'b1;

    logic [0:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             accept, is_start, is_tick;

    assign s_tready = (state_reg == ST_IDLE) && !skid_full;
    assign accept   = s_tvalid && s_tready;
    assign is_start = accept && (s_tuser == FUNC_START);
    // A tick with no line in progress is dropped.
    assign is_tick  = accept && (s_tuser == FUNC_TICK) && busy_reg;

    assign cmd.load_line = is_start;
    assign cmd.advance   = is_tick;
    assign cmd.div_step  = (state_reg == ST_DIV);

    assign push      = is_start || is_tick;
    assign push_last = is_start ? stat.steps_zero : stat.final_pixel;
    assign busy      = busy_reg;
    assign dividing  = (state_reg == ST_DIV);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (is_start && !stat.steps_zero) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (is_start) begin
            busy_next = !stat.steps_zero;
        end else if (is_tick && stat.final_pixel) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

// ===== rtl/dda_dpath.sv =====
// ----------------------------------------------------------------------------
// dda_dpath: arithmetic of the DDA line rasterizer
// Two lanes (x and y), each with a bit-serial restoring divider for the
// increment and an accumulator with round-half-up pixel output.
// ----------------------------------------------------------------------------
module dda_dpath #(
    parameter int COORD_BITS = 9,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            aclk,
    input  dda_pkg::dda_cmd_t               cmd,
    input  logic [COORD_BITS-1:0]           start_x,
    input  logic [COORD_BITS-1:0]           start_y,
    input  logic [COORD_BITS-1:0]           end_x,
    input  logic [COORD_BITS-1:0]           end_y,
    input  logic [dda_pkg::COLOR_BITS-1:0]  line_color,
    output dda_pkg::dda_stat_t              stat,
    output logic [COORD_BITS-1:0]           pixel_x,
    output logic [COORD_BITS-1:0]           pixel_y,
    output logic [dda_pkg::COLOR_BITS-1:0]  pixel_color
);
    import dda_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int ACC_W = COORD_BITS + FRAC_BITS;
    localparam int Q_W   = FRAC_BITS + 1;  // |d| <= steps, so quotient <= 2^FRAC_BITS
    localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

    logic [CB-1:0]         divisor_reg;
    logic [CB-1:0]         left_reg;
    logic [COLOR_BITS-1:0] color_reg;

    logic [ACC_W-1:0] num_reg [2];
    logic [CB-1:0]    rem_reg [2];
    logic [Q_W-1:0]   quo_reg [2];
    logic             neg_reg [2];
    logic [ACC_W-1:0] acc_reg [2];

    logic [CB-1:0]    p0 [2];
    logic [CB-1:0]    p1 [2];
    logic [CB:0]      diff [2];
    logic             neg [2];
    logic [CB-1:0]    mag [2];
    logic [CB-1:0]    steps;
    logic [CB:0]      trial [2];
    logic             fits [2];
    logic [CB:0]      trial_sub [2];
    logic [ACC_W-1:0] acc_upd [2];
    logic [ACC_W:0]   rsum [2];
    logic [CB-1:0]    pix [2];

    assign p0[0] = start_x;
    assign p0[1] = start_y;
    assign p1[0] = end_x;
    assign p1[1] = end_y;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            diff[i]      = {1'b0, p1[i]} - {1'b0, p0[i]};
            neg[i]       = diff[i][CB];
            mag[i]       = neg[i] ? CB'(-diff[i]) : diff[i][CB-1:0];
            trial[i]     = {rem_reg[i], num_reg[i][ACC_W-1]};
            fits[i]      = trial[i] >= {1'b0, divisor_reg};
            trial_sub[i] = trial[i] - {1'b0, divisor_reg};
            // Truncation toward zero: step the magnitude quotient in the sign's direction.
            acc_upd[i]   = neg_reg[i]
                         ? acc_reg[i] - {{(ACC_W-Q_W){1'b0}}, quo_reg[i]}
                         : acc_reg[i] + {{(ACC_W-Q_W){1'b0}}, quo_reg[i]};
            rsum[i]      = {1'b0, acc_upd[i]} + HALF;
            pix[i]       = rsum[i][ACC_W-1:FRAC_BITS];
        end
    end

    assign steps = (mag[0] >= mag[1]) ? mag[0] : mag[1];

    assign stat.steps_zero  = (steps == '0);
    assign stat.final_pixel = (left_reg == CB'(1));

    assign pixel_x     = cmd.load_line ? start_x : pix[0];
    assign pixel_y     = cmd.load_line ? start_y : pix[1];
    assign pixel_color = cmd.load_line ? line_color : color_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_line) begin
            divisor_reg <= steps;
            left_reg    <= steps;
            color_reg   <= line_color;
        end else if (cmd.advance) begin
            left_reg <= left_reg - 1'b1;
        end
        for (int i = 0; i < 2; i++) begin
            if (cmd.load_line) begin
                num_reg[i] <= {mag[i], {FRAC_BITS{1'b0}}};
                rem_reg[i] <= '0;
                quo_reg[i] <= '0;
                neg_reg[i] <= neg[i];
                acc_reg[i] <= {p0[i], {FRAC_BITS{1'b0}}};
            end else begin
                if (cmd.div_step) begin
                    num_reg[i] <= {num_reg[i][ACC_W-2:0], 1'b0};
                    rem_reg[i] <= fits[i] ? trial_sub[i][CB-1:0] : trial[i][CB-1:0];
                    quo_reg[i] <= {quo_reg[i][Q_W-2:0], fits[i]};
                end
                if (cmd.advance) begin
                    acc_reg[i] <= acc_upd[i];
                end
            end
        end
    end

endmodule

// ===== rtl/dda_obuf.sv =====
// ----------------------------------------------------------------------------
// dda_obuf: output register with a skid stage
// Holds the word on the result channel and catches one more word while
// the receiver stalls.
// ----------------------------------------------------------------------------
module dda_obuf #(
    parameter int WIDTH = 43
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             skid_full,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [WIDTH-1:0] m_data
);
    import dda_pkg::*;

    logic             out_v_reg, skid_v_reg;
    logic [WIDTH-1:0] out_reg, skid_reg;
    logic             drain;

    assign drain     = !out_v_reg || m_tready;
    assign skid_full = skid_v_reg;
    assign m_tvalid  = out_v_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (drain) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg <= push;
            end
        end else if (push) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (drain) begin
            if (skid_v_reg) begin
                out_reg <= skid_reg;
            end else if (push) begin
                out_reg <= push_data;
            end
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

endmodule

// ===== rtl/dda_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer: fixed-point DDA line drawer
// Turns a start word and a series of tick words into the pixels of a line.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_) carries one word per command. s_tuser selects the
// function: 0 starts a line from the endpoints and color in s_tdata, 1 is a
// tick that asks for the next pixel. The result channel (m_) carries one
// pixel word per start and per tick of a line in progress; m_tlast marks
// the final pixel. A tick with no line in progress yields no word.
// Output: a pixel word is registered at the edge that accepts the command,
// into the output register, or into the skid stage while the receiver stalls.
// Throughput: a line streams at one pixel per clock while the receiver
// keeps up; a full skid stage holds s_tready low. After a start, a
// bit-serial divider forms both increments, and s_tready is low during
// that time. A zero-length line needs no division.
// A start abandons any line in progress.
// Reset: aresetn is synchronous and active low; it drops the line in
// progress and empties the output register and skid stage.
// Stall: while m_tready is low the result word holds; one more word is
// caught in a skid stage, after which s_tready goes low until it drains.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
    parameter int COORD_BITS = 9,
    parameter int FRAC_BITS  = 16,
    localparam int S_TDATA_W = ((4 * COORD_BITS + dda_pkg::COLOR_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((2 * COORD_BITS + dda_pkg::COLOR_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: start_x, start_y, end_x, end_y, line_color (lowest bits first).
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: func.
    input  logic                 s_tuser,
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: pixel_x, pixel_y, pixel_color (lowest bits first).
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);
    import dda_pkg::*;

    localparam int CB      = COORD_BITS;
    localparam int DIV_LEN = COORD_BITS + FRAC_BITS;
    localparam int OB_W    = 2 * COORD_BITS + COLOR_BITS + 1;

    dda_cmd_t              cmd;
    dda_stat_t             stat;
    logic                  push, push_last, skid_full, busy, dividing;
    logic [CB-1:0]         start_x, start_y, end_x, end_y;
    logic [COLOR_BITS-1:0] line_color;
    logic [CB-1:0]         pixel_x, pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic [OB_W-1:0]       ob_out;

    // Unpack the input word.
    assign start_x    = s_tdata[CB-1:0];
    assign start_y    = s_tdata[2*CB-1:CB];
    assign end_x      = s_tdata[3*CB-1:2*CB];
    assign end_y      = s_tdata[4*CB-1:3*CB];
    assign line_color = s_tdata[4*CB+COLOR_BITS-1:4*CB];

    dda_ctrl #(
        .DIV_LEN (DIV_LEN)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tuser   (s_tuser),
        .s_tready  (s_tready),
        .skid_full (skid_full),
        .stat      (stat),
        .cmd       (cmd),
        .push      (push),
        .push_last (push_last),
        .busy      (busy),
        .dividing  (dividing)
    );

    dda_dpath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .cmd         (cmd),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .line_color  (line_color),
        .stat        (stat),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color)
    );

    // The skid stage carries last together with the pixel.
    dda_obuf #(
        .WIDTH (OB_W)
    ) u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_last, pixel_color, pixel_y, pixel_x}),
        .skid_full (skid_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (ob_out)
    );

    assign m_tdata = M_TDATA_W'(ob_out[OB_W-2:0]);
    assign m_tlast = ob_out[OB_W-1];

    // No command may be taken while the divider is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        dividing |-> !s_tready)
        else $error("input accepted during increment division");

    // The skid stage is only ever filled behind a held result word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full |-> m_tvalid)
        else $error("skid stage occupied with empty output register");

    // A line only ends together with a pixel flagged last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy) |-> $past(push && push_last))
        else $error("line ended without a final pixel");

    // A line in progress always has pixels left to emit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !push_last) |=> busy)
        else $error("non-final pixel left the rasterizer idle");

endmodule

// ===== sim/dda_line_rasterizer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer_test: self-checking bench of the DDA line rasterizer
// Feeds start and tick words and predicts every pixel word in fixed point.
// Each pixel word that leaves the block is compared field by field with the
// oldest prediction. Directed tests come first, then random lines under four
// patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_test;
    import dda_pkg::*;

    localparam int COORD_W    = 9;
    localparam int FRAC_W     = 16;
    localparam int S_W        = 64;
    localparam int M_W        = 48;
    localparam int COORD_MAX  = (1 << COORD_W) - 1;
    // Cycles without any handshake on either channel before the run is
    // declared hung. A start word blocks the input while the divider runs,
    // and the receiver may stall for long random streaks, so this is generous.
    localparam int HANG_LIMIT = 2000;
    // Cycles to wait after the last pixel word, well above the divide time.
    localparam int SETTLE_CYCLES = 40;

    // One predicted pixel word.
    typedef struct {
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;
    logic           s_tuser  = FUNC_START;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic           m_tlast;

    // Pixel words predicted but not yet seen on the result channel.
    pixel_t pending_pixels[$];
    int     error_count = 0;
    int     quiet_cycles = 0;
    // Percent chances of a sender gap and of a receiver stall per cycle.
    int     send_gap_pct = 0;
    int     recv_stall_pct = 0;

    // Shadow copy of the line state, kept in step with every accepted word.
    logic                     line_busy = 1'b0;
    logic [COORD_W+FRAC_W-1:0] acc_x = '0;
    logic [COORD_W+FRAC_W-1:0] acc_y = '0;
    logic signed [COORD_W+FRAC_W:0] inc_x = '0;
    logic signed [COORD_W+FRAC_W:0] inc_y = '0;
    logic [COORD_W:0]         pixels_to_go = '0;
    logic [COLOR_BITS-1:0]    line_rgb = '0;

    dda_line_rasterizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Round an accumulator half up to the nearest whole coordinate.
    function automatic logic [COORD_W-1:0] round_acc(input logic [COORD_W+FRAC_W-1:0] acc);
        logic [COORD_W+FRAC_W:0] sum;
        sum = {1'b0, acc} + (COORD_W+FRAC_W+1)'(1 << (FRAC_W - 1));
        return sum[COORD_W+FRAC_W-1:FRAC_W];
    endfunction

    // Update the shadow line state for one accepted word and queue the pixel
    // word that it causes, if any.
    task automatic predict_pixel(input logic func, input logic [S_W-1:0] data);
        longint dx;
        longint dy;
        longint steps;
        longint next_x;
        longint next_y;
        pixel_t px;
        if (func == FUNC_START) begin
            dx = longint'(data[26:18]) - longint'(data[8:0]);
            dy = longint'(data[35:27]) - longint'(data[17:9]);
            steps = (dx < 0) ? -dx : dx;
            if (((dy < 0) ? -dy : dy) > steps) steps = (dy < 0) ? -dy : dy;
            line_rgb = data[59:36];
            acc_x = {data[8:0], {FRAC_W{1'b0}}};
            acc_y = {data[17:9], {FRAC_W{1'b0}}};
            if (steps == 0) begin
                // A line whose endpoints coincide is a single final pixel.
                inc_x = '0;
                inc_y = '0;
                pixels_to_go = '0;
                line_busy = 1'b0;
                px.last = 1'b1;
            end else begin
                // SystemVerilog division truncates toward zero, as required.
                inc_x = (COORD_W+FRAC_W+1)'((dx * (longint'(1) << FRAC_W)) / steps);
                inc_y = (COORD_W+FRAC_W+1)'((dy * (longint'(1) << FRAC_W)) / steps);
                pixels_to_go = (COORD_W+1)'(steps);
                line_busy = 1'b1;
                px.last = 1'b0;
            end
        end else if (line_busy) begin
            next_x = longint'(acc_x) + longint'(inc_x);
            next_y = longint'(acc_y) + longint'(inc_y);
            if (next_x < 0) next_x = 0;
            if (next_y < 0) next_y = 0;
            acc_x = (COORD_W+FRAC_W)'(next_x);
            acc_y = (COORD_W+FRAC_W)'(next_y);
            pixels_to_go = pixels_to_go - 1'b1;
            px.last = (pixels_to_go == 0);
            if (px.last) line_busy = 1'b0;
        end else begin
            // A tick with no line in progress is simply dropped.
            return;
        end
        px.x = round_acc(acc_x);
        px.y = round_acc(acc_y);
        px.color = line_rgb;
        pending_pixels.push_back(px);
    endtask

    // Offer one word on the input channel, with random gaps in front of it,
    // and hold it until the block takes it. The valid line is left high so
    // that back-to-back words need no extra edge.
    task automatic send_word(input logic func, input logic [S_W-1:0] data);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        predict_pixel(func, data);
    endtask

    task automatic send_start(input int x0, input int y0, input int x1, input int y1,
                              input logic [COLOR_BITS-1:0] rgb);
        send_word(FUNC_START, {4'b0, rgb, 9'(y1), 9'(x1), 9'(y0), 9'(x0)});
    endtask

    // The payload of a tick is ignored by the block, so it carries noise.
    task automatic send_tick();
        send_word(FUNC_TICK, {4'b0, 28'($urandom), 32'($urandom)});
    endtask

    // Ticks with nothing in progress, with the payload all ones and all zeros.
    task automatic test_idle_tick();
        send_word(FUNC_TICK, {4'b0, {60{1'b1}}});
        send_word(FUNC_TICK, '0);
    endtask

    // Lines whose endpoints coincide, at both corners of the coordinate range.
    task automatic test_zero_length();
        send_start(0, 0, 0, 0, 24'h000000);
        send_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 24'hFFFFFF);
        send_tick();
    endtask

    // A short shallow line run to its end, then one tick past the end.
    task automatic test_short_line();
        send_start(0, 0, 5, 2, 24'h123456);
        repeat (5) send_tick();
        send_tick();
    endtask

    // Full-range diagonals cut short by a new start, then a short line that
    // runs toward the origin and finishes.
    task automatic test_abandoned_line();
        send_start(0, COORD_MAX, COORD_MAX, 0, 24'hFFFFFF);
        repeat (3) send_tick();
        send_start(COORD_MAX, 0, 0, COORD_MAX, 24'h000000);
        repeat (2) send_tick();
        send_start(COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX - 2, 24'hA5A5A5);
        repeat (3) send_tick();
    endtask

    function automatic int clamp_coord(input int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // Random lines with random content. Most are short; a few have endpoints
    // anywhere in the range. Some are abandoned early, some get an extra tick
    // past their end, and a share of the words are raw noise.
    task automatic test_random_lines(input int gap_pct, input int stall_pct,
                                     input int word_target);
        int words_sent;
        int x0;
        int y0;
        int x1;
        int y1;
        int steps;
        int ticks;
        int extra;
        logic [S_W-1:0] noise;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        words_sent = 0;
        while (words_sent < word_target) begin
            if ($urandom_range(99) < 10) begin
                noise = {4'b0, 28'($urandom), 32'($urandom)};
                if ($urandom_range(1) == 0) begin
                    send_word(FUNC_START, noise);
                end else begin
                    send_word(FUNC_TICK, noise);
                end
                words_sent++;
            end else begin
                x0 = $urandom_range(COORD_MAX);
                y0 = $urandom_range(COORD_MAX);
                if ($urandom_range(39) == 0) begin
                    x1 = $urandom_range(COORD_MAX);
                    y1 = $urandom_range(COORD_MAX);
                end else begin
                    x1 = clamp_coord(x0 + int'($urandom_range(24)) - 12);
                    y1 = clamp_coord(y0 + int'($urandom_range(24)) - 12);
                end
                steps = (x1 > x0) ? x1 - x0 : x0 - x1;
                if (((y1 > y0) ? y1 - y0 : y0 - y1) > steps) begin
                    steps = (y1 > y0) ? y1 - y0 : y0 - y1;
                end
                ticks = steps;
                if ($urandom_range(6) == 0) ticks = $urandom_range(steps);
                send_start(x0, y0, x1, y1, 24'($urandom));
                repeat (ticks) send_tick();
                extra = 0;
                if (ticks == steps) extra = $urandom_range(1);
                repeat (extra) send_tick();
                words_sent += ticks + 1 + extra;
            end
        end
    endtask

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker and hang watchdog. Values read here are those before
    // the edge, so the handshake seen is the one completed at this edge.
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (pending_pixels.size() == 0) begin
                    $error("unexpected pixel word: x %0d y %0d color %06h last %0b",
                           m_tdata[8:0], m_tdata[17:9], m_tdata[41:18], m_tlast);
                    error_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_tdata[8:0] !== want.x) begin
                        $error("pixel_x: expected %0d, actual %0d", want.x, m_tdata[8:0]);
                        error_count++;
                    end
                    if (m_tdata[17:9] !== want.y) begin
                        $error("pixel_y: expected %0d, actual %0d", want.y, m_tdata[17:9]);
                        error_count++;
                    end
                    if (m_tdata[41:18] !== want.color) begin
                        $error("pixel_color: expected %06h, actual %06h",
                               want.color, m_tdata[41:18]);
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        // Hold reset with every input at a known value.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed checks run with no idling on either side.
        test_idle_tick();
        test_zero_length();
        test_short_line();
        test_abandoned_line();

        // Random lines under each idling pattern in turn.
        test_random_lines(0, 0, 225);
        test_random_lines(83, 0, 225);
        test_random_lines(0, 83, 225);
        test_random_lines(38, 38, 225);

        s_tvalid <= 1'b0;
        // Drain every predicted pixel word; the watchdog covers a hang here.
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
